/* design/lcdn_pkg.sv */
`default_nettype none

package lcdn_pkg;

  localparam int unsigned CURSOR_LIMIT_DEF = 80;

  localparam logic [19:0] NIBBLE_TICKS = 20'd102;
  localparam logic [19:0] WAIT_POWER_UP = 20'd40000;
  localparam logic [19:0] WAIT_WAKE_1 = 20'd5000;
  localparam logic [19:0] WAIT_WAKE_2 = 20'd100;
  localparam logic [19:0] WAIT_SETTLE = 20'd1000000;

  localparam logic [7:0] WAKE_NIBBLE = 8'h03;
  localparam logic [7:0] FOUR_BIT_NIBBLE = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0E;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME = 8'h02;
  localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h14;
  localparam logic [7:0] CMD_SHIFT_LEFT = 8'h10;

  localparam int unsigned CFG_DATA_W = 12;
  localparam logic CFG_COMMAND_WAIT = 1'b0;
  localparam logic CFG_CLEAR_WAIT = 1'b1;
  localparam logic [9:0] COMMAND_WAIT_RST = 10'd100;
  localparam logic [11:0] CLEAR_WAIT_RST = 12'd2000;

  typedef enum logic [2:0] {
    FUNC_TICK = 3'd0,
    FUNC_INIT = 3'd1,
    FUNC_CMD = 3'd2,
    FUNC_CHAR = 3'd3,
    FUNC_CLEAR = 3'd4,
    FUNC_HOME = 3'd5,
    FUNC_CURSOR = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_INIT = 3'd1,
    PH_CMD = 3'd2,
    PH_CHAR = 3'd3,
    PH_CLEAR = 3'd4,
    PH_HOME = 3'd5,
    PH_CURSOR = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    K_END,
    K_WAIT,
    K_WAITCLR,
    K_WAITCMD,
    K_NIB,
    K_BYTE
  } kind_e;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0,
    ERR_BUSY = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef struct packed {
    kind_e kind;
    logic [19:0] arg;
  } step_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
  } in_word_t;

  typedef struct packed {
    logic reg_select;
    logic enable_pin;
    logic [3:0] data_nibble;
    logic busy_res;
    logic [6:0] cursor;
    logic [1:0] error;
  } out_word_t;

  typedef struct packed {
    logic [9:0] command_wait_us;
    logic [11:0] clear_wait_us;
  } cfg_t;

  function automatic step_t init_step_info(logic [3:0] idx);
    step_t s;
    s.kind = K_END;
    s.arg = '0;
    case (idx)
      4'd0: begin
        s.kind = K_WAIT;
        s.arg = WAIT_POWER_UP;
      end
      4'd1: begin
        s.kind = K_NIB;
        s.arg = 20'(WAKE_NIBBLE);
      end
      4'd2: begin
        s.kind = K_WAIT;
        s.arg = WAIT_WAKE_1;
      end
      4'd3: begin
        s.kind = K_NIB;
        s.arg = 20'(WAKE_NIBBLE);
      end
      4'd4: begin
        s.kind = K_WAIT;
        s.arg = WAIT_WAKE_2;
      end
      4'd5: begin
        s.kind = K_NIB;
        s.arg = 20'(WAKE_NIBBLE);
      end
      4'd6: begin
        s.kind = K_NIB;
        s.arg = 20'(FOUR_BIT_NIBBLE);
      end
      4'd7: begin
        s.kind = K_BYTE;
        s.arg = 20'(CMD_FUNC_SET);
      end
      4'd8: begin
        s.kind = K_BYTE;
        s.arg = 20'(CMD_DISPLAY_ON);
      end
      4'd9: begin
        s.kind = K_BYTE;
        s.arg = 20'(CMD_CLEAR);
      end
      4'd10: begin
        s.kind = K_WAITCLR;
      end
      4'd11: begin
        s.kind = K_BYTE;
        s.arg = 20'(CMD_ENTRY_MODE);
      end
      4'd12: begin
        s.kind = K_WAIT;
        s.arg = WAIT_SETTLE;
      end
      default: begin
        s.kind = K_END;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/char_lcd_nibble_interface_unit.sv */
// Character LCD controller on a 4-bit bus (RS, EN, D7..D4).
// Input channel: in_valid_i / in_stall_o carry one word {func, value}:
// a one-microsecond tick, or a request (init, command, character, clear,
// home, set cursor). Requests are taken only while the controller is idle;
// otherwise they come back with a busy error. The pins change on ticks.
// Output channel: out_valid_o / out_stall_i carry one result word per input
// word: pin levels, busy flag, tracked cursor and error code.
// A word accepted into the input register has its result written to the
// output register, with out_valid_o high, when the output register can advance.
// Throughput: one word per cycle while out_stall_i holds no result; each word
// does a constant amount of work on the sequencer state in a single pass.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 command
// wait, 1 clear wait); write only while no word is in flight.
// Reset: sequencer idle, cursor 0, all pins low, waits back to 100 and 2000.
// Stall: while out_stall_i holds a result, the input register keeps its
// word and in_stall_o rises once it is full.
`default_nettype none

module char_lcd_nibble_interface_unit #(
  parameter int unsigned CURSOR_LIMIT = lcdn_pkg::CURSOR_LIMIT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  lcdn_pkg::in_word_t                   in_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output lcdn_pkg::out_word_t                  out_word_o,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [lcdn_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic in_valid_q;
  lcdn_pkg::in_word_t in_word_q;
  logic out_valid_q;
  lcdn_pkg::out_word_t out_word_q;
  lcdn_pkg::out_word_t result;
  lcdn_pkg::cfg_t cfg;
  logic advance;
  logic accept;
  logic fire;

  assign advance = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept = in_valid_i && !in_stall_o;
  assign fire = in_valid_q && advance;

  lcdn_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lcdn_core #(
    .CURSOR_LIMIT (CURSOR_LIMIT)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_word_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o = out_word_q;

`ifndef SYNTH
  a_word_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("held word did not reach the output register");
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_q && advance) |=> !out_valid_q)
    else $error("result word without an input word");
`endif

endmodule

`default_nettype wire

/* design/lcdn_cfg.sv */
`default_nettype none

module lcdn_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [lcdn_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output lcdn_pkg::cfg_t                         cfg_o
);

  logic [9:0] command_wait_q;
  logic [11:0] clear_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_wait_q <= lcdn_pkg::COMMAND_WAIT_RST;
      clear_wait_q <= lcdn_pkg::CLEAR_WAIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcdn_pkg::CFG_COMMAND_WAIT: command_wait_q <= cfg_data_i[9:0];
        lcdn_pkg::CFG_CLEAR_WAIT: clear_wait_q <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.command_wait_us = command_wait_q;
  assign cfg_o.clear_wait_us = clear_wait_q;

endmodule

`default_nettype wire

/* design/lcdn_core.sv */
`default_nettype none

module lcdn_core #(
  parameter int unsigned CURSOR_LIMIT = lcdn_pkg::CURSOR_LIMIT_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  lcdn_pkg::in_word_t  item_i,
  input  lcdn_pkg::cfg_t      cfg_i,
  output lcdn_pkg::out_word_t result_o
);

  localparam logic [7:0] LimitW = 8'(CURSOR_LIMIT);

  typedef struct packed {
    lcdn_pkg::phase_e phase;
    logic [3:0] step;
    logic [19:0] wait_cnt;
    logic [7:0] byte_val;
    logic low;
  } seq_t;

  function automatic lcdn_pkg::step_t step_info(seq_t s, logic [6:0] pos, logic [6:0] target);
    lcdn_pkg::step_t r;
    r.kind = lcdn_pkg::K_END;
    r.arg = '0;
    case (s.phase)
      lcdn_pkg::PH_INIT: r = lcdn_pkg::init_step_info(s.step);
      lcdn_pkg::PH_CMD: begin
        if (s.step == 4'd0) begin
          r.kind = lcdn_pkg::K_BYTE;
          r.arg = 20'(s.byte_val);
        end else if (s.step == 4'd1) begin
          r.kind = lcdn_pkg::K_WAITCMD;
        end
      end
      lcdn_pkg::PH_CHAR: begin
        if (s.step == 4'd0) begin
          r.kind = lcdn_pkg::K_BYTE;
          r.arg = 20'(s.byte_val);
        end
      end
      lcdn_pkg::PH_CLEAR, lcdn_pkg::PH_HOME: begin
        if (s.step == 4'd0) begin
          r.kind = lcdn_pkg::K_BYTE;
          r.arg = (s.phase == lcdn_pkg::PH_CLEAR) ? 20'(lcdn_pkg::CMD_CLEAR)
                                                  : 20'(lcdn_pkg::CMD_HOME);
        end else if (s.step == 4'd1) begin
          r.kind = lcdn_pkg::K_WAITCLR;
        end
      end
      lcdn_pkg::PH_CURSOR: begin
        if (pos != target) begin
          r.kind = lcdn_pkg::K_BYTE;
          r.arg = (pos < target) ? 20'(lcdn_pkg::CMD_SHIFT_RIGHT)
                                 : 20'(lcdn_pkg::CMD_SHIFT_LEFT);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [19:0] wait_len(lcdn_pkg::step_t a, lcdn_pkg::cfg_t cfg);
    logic [19:0] n;
    case (a.kind)
      lcdn_pkg::K_WAIT: n = a.arg;
      lcdn_pkg::K_WAITCLR: n = 20'(cfg.clear_wait_us);
      lcdn_pkg::K_WAITCMD: n = 20'(cfg.command_wait_us);
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic seq_t take(seq_t s, lcdn_pkg::step_t a, lcdn_pkg::cfg_t cfg);
    seq_t r;
    r = s;
    case (a.kind)
      lcdn_pkg::K_END: begin
        r.phase = lcdn_pkg::PH_IDLE;
        r.step = '0;
        r.wait_cnt = '0;
      end
      lcdn_pkg::K_NIB, lcdn_pkg::K_BYTE: begin
        r.byte_val = a.arg[7:0];
        r.low = (a.kind == lcdn_pkg::K_NIB);
        r.wait_cnt = lcdn_pkg::NIBBLE_TICKS;
      end
      default: r.wait_cnt = wait_len(a, cfg);
    endcase
    return r;
  endfunction

  function automatic seq_t start_seq(seq_t s, logic [6:0] pos, logic [6:0] target,
                                     lcdn_pkg::cfg_t cfg);
    seq_t s1;
    lcdn_pkg::step_t a;
    s1 = s;
    a = step_info(s, pos, target);
    if (a.kind != lcdn_pkg::K_END && a.kind != lcdn_pkg::K_NIB &&
        a.kind != lcdn_pkg::K_BYTE && wait_len(a, cfg) == '0) begin
      s1.step = s.step + 4'd1;
      a = step_info(s1, pos, target);
    end
    return take(s1, a, cfg);
  endfunction

  seq_t seq_q, seq_d;
  logic [6:0] pos_q, pos_d;
  logic [6:0] target_q, target_d;
  logic rs_q, rs_d;
  logic en_q, en_d;
  logic [3:0] nib_q, nib_d;
  lcdn_pkg::err_e err;

  always_comb begin
    seq_t req;
    seq_t fin;
    lcdn_pkg::step_t a;
    logic [19:0] wcnt;
    logic [7:0] pos_inc;
    logic do_finish;
    seq_d = seq_q;
    pos_d = pos_q;
    target_d = target_q;
    rs_d = rs_q;
    en_d = en_q;
    nib_d = nib_q;
    err = lcdn_pkg::ERR_OK;
    req = seq_q;
    fin = seq_q;
    a = step_info(seq_q, pos_q, target_q);
    wcnt = '0;
    pos_inc = {1'b0, pos_q} + 8'd1;
    do_finish = 1'b0;
    if (fire_i) begin
      if (item_i.func == lcdn_pkg::FUNC_TICK) begin
        if (seq_q.phase != lcdn_pkg::PH_IDLE) begin
          case (a.kind)
            lcdn_pkg::K_END: seq_d = start_seq(seq_q, pos_q, target_q, cfg_i);
            lcdn_pkg::K_NIB, lcdn_pkg::K_BYTE: begin
              if (seq_q.wait_cnt == lcdn_pkg::NIBBLE_TICKS) begin
                rs_d = (seq_q.phase == lcdn_pkg::PH_CHAR);
                en_d = 1'b0;
                nib_d = seq_q.low ? seq_q.byte_val[3:0] : seq_q.byte_val[7:4];
              end else if (seq_q.wait_cnt == lcdn_pkg::NIBBLE_TICKS - 20'd1) begin
                en_d = 1'b1;
              end else begin
                en_d = 1'b0;
              end
              wcnt = seq_q.wait_cnt - 20'd1;
              seq_d.wait_cnt = wcnt;
              if (wcnt == '0 || wcnt > lcdn_pkg::NIBBLE_TICKS) begin
                if (!seq_q.low) begin
                  seq_d.low = 1'b1;
                  seq_d.wait_cnt = lcdn_pkg::NIBBLE_TICKS;
                end else begin
                  do_finish = 1'b1;
                end
              end
            end
            default: begin
              wcnt = (seq_q.wait_cnt == '0) ? '0 : seq_q.wait_cnt - 20'd1;
              seq_d.wait_cnt = wcnt;
              do_finish = (wcnt == '0);
            end
          endcase
        end
      end else if (item_i.func <= lcdn_pkg::FUNC_CURSOR) begin
        if (seq_q.phase != lcdn_pkg::PH_IDLE) begin
          err = lcdn_pkg::ERR_BUSY;
        end else if (item_i.func == lcdn_pkg::FUNC_CURSOR && item_i.value >= LimitW) begin
          err = lcdn_pkg::ERR_RANGE;
        end else begin
          req.phase = lcdn_pkg::phase_e'(item_i.func);
          req.step = '0;
          if (item_i.func == lcdn_pkg::FUNC_CMD || item_i.func == lcdn_pkg::FUNC_CHAR) begin
            req.byte_val = item_i.value;
          end
          if (item_i.func == lcdn_pkg::FUNC_CURSOR) begin
            target_d = item_i.value[6:0];
          end
          seq_d = start_seq(req, pos_q, target_d, cfg_i);
        end
      end
    end
    if (do_finish) begin
      if (a.kind == lcdn_pkg::K_BYTE) begin
        case (seq_q.phase)
          lcdn_pkg::PH_CHAR: pos_d = (pos_inc >= LimitW) ? '0 : pos_inc[6:0];
          lcdn_pkg::PH_CLEAR, lcdn_pkg::PH_HOME: pos_d = '0;
          lcdn_pkg::PH_INIT: begin
            if (seq_q.byte_val == lcdn_pkg::CMD_CLEAR) pos_d = '0;
          end
          lcdn_pkg::PH_CURSOR: begin
            pos_d = (seq_q.byte_val == lcdn_pkg::CMD_SHIFT_RIGHT) ? pos_q + 7'd1
                                                                  : pos_q - 7'd1;
          end
          default: begin
          end
        endcase
      end
      fin = seq_d;
      if (seq_q.phase != lcdn_pkg::PH_CURSOR) fin.step = seq_d.step + 4'd1;
      seq_d = start_seq(fin, pos_d, target_q, cfg_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q.phase <= lcdn_pkg::PH_IDLE;
      seq_q.step <= '0;
      seq_q.wait_cnt <= '0;
      seq_q.byte_val <= '0;
      seq_q.low <= 1'b0;
      pos_q <= '0;
      target_q <= '0;
      rs_q <= 1'b0;
      en_q <= 1'b0;
      nib_q <= '0;
    end else if (fire_i) begin
      seq_q <= seq_d;
      pos_q <= pos_d;
      target_q <= target_d;
      rs_q <= rs_d;
      en_q <= en_d;
      nib_q <= nib_d;
    end
  end

  assign result_o.reg_select = rs_d;
  assign result_o.enable_pin = en_d;
  assign result_o.data_nibble = nib_d;
  assign result_o.busy_res = (seq_d.phase != lcdn_pkg::PH_IDLE);
  assign result_o.cursor = pos_d;
  assign result_o.error = err;

`ifndef SYNTH
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q.phase == lcdn_pkg::PH_IDLE |-> (seq_q.step == '0 && seq_q.wait_cnt == '0))
    else $error("idle with leftover step or wait");
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < LimitW)
    else $error("cursor beyond limit");
  a_en_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_q |-> seq_q.phase != lcdn_pkg::PH_IDLE)
    else $error("EN left high outside a sequence");
`endif

endmodule

`default_nettype wire

/* tb/char_lcd_nibble_interface_unit_tb.sv */
`timescale 1ns / 1ps

module char_lcd_nibble_interface_unit_tb;

  localparam int unsigned CUR_LIMIT = lcdn_pkg::CURSOR_LIMIT_DEF;
  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam int unsigned INIT_STEPS = 13;
  localparam lcdn_pkg::kind_e INIT_KIND [INIT_STEPS] = '{
    lcdn_pkg::K_WAIT, lcdn_pkg::K_NIB, lcdn_pkg::K_WAIT, lcdn_pkg::K_NIB,
    lcdn_pkg::K_WAIT, lcdn_pkg::K_NIB, lcdn_pkg::K_NIB, lcdn_pkg::K_BYTE,
    lcdn_pkg::K_BYTE, lcdn_pkg::K_BYTE, lcdn_pkg::K_WAITCLR, lcdn_pkg::K_BYTE,
    lcdn_pkg::K_WAIT
  };
  localparam logic [19:0] INIT_ARG [INIT_STEPS] = '{
    lcdn_pkg::WAIT_POWER_UP, 20'(lcdn_pkg::WAKE_NIBBLE), lcdn_pkg::WAIT_WAKE_1,
    20'(lcdn_pkg::WAKE_NIBBLE), lcdn_pkg::WAIT_WAKE_2, 20'(lcdn_pkg::WAKE_NIBBLE),
    20'(lcdn_pkg::FOUR_BIT_NIBBLE), 20'(lcdn_pkg::CMD_FUNC_SET),
    20'(lcdn_pkg::CMD_DISPLAY_ON), 20'(lcdn_pkg::CMD_CLEAR), 20'd0,
    20'(lcdn_pkg::CMD_ENTRY_MODE), lcdn_pkg::WAIT_SETTLE
  };

  localparam lcdn_pkg::out_word_t AT_RESET =
    '{1'b0, 1'b0, 4'h0, 1'b0, 7'd0, lcdn_pkg::ERR_OK};
  localparam lcdn_pkg::out_word_t RANGE_REFUSED =
    '{1'b0, 1'b0, 4'h0, 1'b0, 7'd0, lcdn_pkg::ERR_RANGE};
  localparam lcdn_pkg::out_word_t CMD_TAKEN =
    '{1'b0, 1'b0, 4'h0, 1'b1, 7'd0, lcdn_pkg::ERR_OK};
  localparam lcdn_pkg::out_word_t BUSY_REFUSED =
    '{1'b0, 1'b0, 4'h0, 1'b1, 7'd0, lcdn_pkg::ERR_BUSY};
  localparam lcdn_pkg::out_word_t HIGH_SET =
    '{1'b0, 1'b0, 4'hF, 1'b1, 7'd0, lcdn_pkg::ERR_OK};
  localparam lcdn_pkg::out_word_t HIGH_STROBE =
    '{1'b0, 1'b1, 4'hF, 1'b1, 7'd0, lcdn_pkg::ERR_OK};

  typedef struct packed {
    logic [2:0]          func;
    logic [7:0]          value;
    logic                run_out;
    logic                typed;
    lcdn_pkg::out_word_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lcdn_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lcdn_pkg::out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [lcdn_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  lcdn_pkg::out_word_t lcd_words_due [$];
  lcdn_pkg::out_word_t due_word;
  int unsigned bad_words = 0;
  bit idle_on = 1'b1;
  bit hold_tog = 1'b0;
  dir_row_t directed [10];

  // predictor state
  lcdn_pkg::phase_e seq_phase = lcdn_pkg::PH_IDLE;
  logic [3:0] seq_step = '0;
  logic [19:0] seq_wait = '0;
  logic [7:0] seq_byte = '0;
  logic low_half = 1'b0;
  logic [6:0] cur_pos = '0;
  logic [6:0] cur_tgt = '0;
  logic pin_rs = 1'b0;
  logic pin_en = 1'b0;
  logic [3:0] pin_nib = '0;
  logic [9:0] cmd_wait = lcdn_pkg::COMMAND_WAIT_RST;
  logic [11:0] clr_wait = lcdn_pkg::CLEAR_WAIT_RST;

  char_lcd_nibble_interface_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic lcdn_pkg::step_t next_step();
    lcdn_pkg::step_t s;
    s.kind = lcdn_pkg::K_END;
    s.arg = '0;
    case (seq_phase)
      lcdn_pkg::PH_INIT: begin
        if (seq_step < INIT_STEPS) begin
          s.kind = INIT_KIND[seq_step];
          s.arg = INIT_ARG[seq_step];
        end
      end
      lcdn_pkg::PH_CMD: begin
        if (seq_step == 4'd0) begin
          s.kind = lcdn_pkg::K_BYTE;
          s.arg = 20'(seq_byte);
        end else if (seq_step == 4'd1) begin
          s.kind = lcdn_pkg::K_WAITCMD;
        end
      end
      lcdn_pkg::PH_CHAR: begin
        if (seq_step == 4'd0) begin
          s.kind = lcdn_pkg::K_BYTE;
          s.arg = 20'(seq_byte);
        end
      end
      lcdn_pkg::PH_CLEAR, lcdn_pkg::PH_HOME: begin
        if (seq_step == 4'd0) begin
          s.kind = lcdn_pkg::K_BYTE;
          s.arg = (seq_phase == lcdn_pkg::PH_CLEAR) ? 20'(lcdn_pkg::CMD_CLEAR)
                                                    : 20'(lcdn_pkg::CMD_HOME);
        end else if (seq_step == 4'd1) begin
          s.kind = lcdn_pkg::K_WAITCLR;
        end
      end
      lcdn_pkg::PH_CURSOR: begin
        if (cur_pos != cur_tgt) begin
          s.kind = lcdn_pkg::K_BYTE;
          s.arg = (cur_pos < cur_tgt) ? 20'(lcdn_pkg::CMD_SHIFT_RIGHT)
                                      : 20'(lcdn_pkg::CMD_SHIFT_LEFT);
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic void start_step();
    lcdn_pkg::step_t s;
    logic [19:0] n;
    for (int g = 0; g < 16; g++) begin
      s = next_step();
      if (s.kind == lcdn_pkg::K_END) begin
        seq_phase = lcdn_pkg::PH_IDLE;
        seq_step = '0;
        seq_wait = '0;
        return;
      end
      if (s.kind == lcdn_pkg::K_NIB || s.kind == lcdn_pkg::K_BYTE) begin
        seq_byte = s.arg[7:0];
        low_half = (s.kind == lcdn_pkg::K_NIB);
        seq_wait = lcdn_pkg::NIBBLE_TICKS;
        return;
      end
      if (s.kind == lcdn_pkg::K_WAIT) n = s.arg;
      else if (s.kind == lcdn_pkg::K_WAITCLR) n = 20'(clr_wait);
      else n = 20'(cmd_wait);
      if (n != '0) begin
        seq_wait = n;
        return;
      end
      seq_step = seq_step + 4'd1;
    end
    seq_phase = lcdn_pkg::PH_IDLE;
    seq_step = '0;
  endfunction

  function automatic void finish_step(lcdn_pkg::kind_e kind);
    if (kind == lcdn_pkg::K_BYTE) begin
      case (seq_phase)
        lcdn_pkg::PH_CHAR: begin
          cur_pos = cur_pos + 7'd1;
          if (cur_pos >= CUR_LIMIT) cur_pos = '0;
        end
        lcdn_pkg::PH_CLEAR, lcdn_pkg::PH_HOME: cur_pos = '0;
        lcdn_pkg::PH_INIT: if (seq_byte == lcdn_pkg::CMD_CLEAR) cur_pos = '0;
        lcdn_pkg::PH_CURSOR: begin
          if (seq_byte == lcdn_pkg::CMD_SHIFT_RIGHT) cur_pos = cur_pos + 7'd1;
          else cur_pos = cur_pos - 7'd1;
        end
        default: ;
      endcase
    end
    if (seq_phase != lcdn_pkg::PH_CURSOR) seq_step = seq_step + 4'd1;
    start_step();
  endfunction

  function automatic void tick_lcd();
    lcdn_pkg::step_t s;
    logic [19:0] k;
    if (seq_phase == lcdn_pkg::PH_IDLE) return;
    s = next_step();
    if (s.kind == lcdn_pkg::K_END) begin
      start_step();
      return;
    end
    if (s.kind == lcdn_pkg::K_NIB || s.kind == lcdn_pkg::K_BYTE) begin
      k = lcdn_pkg::NIBBLE_TICKS - seq_wait;
      if (k == 20'd0) begin
        pin_rs = (seq_phase == lcdn_pkg::PH_CHAR);
        pin_en = 1'b0;
        pin_nib = low_half ? seq_byte[3:0] : seq_byte[7:4];
      end else if (k == 20'd1) begin
        pin_en = 1'b1;
      end else begin
        pin_en = 1'b0;
      end
      seq_wait = seq_wait - 20'd1;
      if (seq_wait == '0 || seq_wait > lcdn_pkg::NIBBLE_TICKS) begin
        if (!low_half) begin
          low_half = 1'b1;
          seq_wait = lcdn_pkg::NIBBLE_TICKS;
        end else begin
          finish_step(s.kind);
        end
      end
      return;
    end
    if (seq_wait > '0) seq_wait = seq_wait - 20'd1;
    if (seq_wait == '0) finish_step(s.kind);
  endfunction

  function automatic lcdn_pkg::out_word_t predict_lcd_word(lcdn_pkg::in_word_t w);
    lcdn_pkg::out_word_t r;
    lcdn_pkg::err_e e;
    e = lcdn_pkg::ERR_OK;
    if (w.func == lcdn_pkg::FUNC_TICK) begin
      tick_lcd();
    end else if (w.func != FUNC_UNUSED) begin
      if (seq_phase != lcdn_pkg::PH_IDLE) begin
        e = lcdn_pkg::ERR_BUSY;
      end else if (w.func == lcdn_pkg::FUNC_CURSOR && w.value >= CUR_LIMIT) begin
        e = lcdn_pkg::ERR_RANGE;
      end else begin
        seq_phase = lcdn_pkg::phase_e'(w.func);
        seq_step = '0;
        if (w.func == lcdn_pkg::FUNC_CMD || w.func == lcdn_pkg::FUNC_CHAR) begin
          seq_byte = w.value;
        end
        if (w.func == lcdn_pkg::FUNC_CURSOR) cur_tgt = w.value[6:0];
        start_step();
      end
    end
    r.reg_select = pin_rs;
    r.enable_pin = pin_en;
    r.data_nibble = pin_nib;
    r.busy_res = (seq_phase != lcdn_pkg::PH_IDLE);
    r.cursor = cur_pos;
    r.error = e;
    return r;
  endfunction

  function automatic string show_word(lcdn_pkg::out_word_t r);
    return $sformatf("rs=%0b en=%0b d=%h busy=%0b cur=%0d err=%0d", r.reg_select,
                     r.enable_pin, r.data_nibble, r.busy_res, r.cursor, r.error);
  endfunction

  task automatic send_lcd_word(input lcdn_pkg::in_word_t w, input logic typed,
                               input lcdn_pkg::out_word_t want);
    lcdn_pkg::out_word_t r;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = predict_lcd_word(w);
    lcd_words_due.push_back(typed ? want : r);
  endtask

  task automatic tick_through_sequence();
    lcdn_pkg::in_word_t w;
    while (seq_phase != lcdn_pkg::PH_IDLE) begin
      w.value = 8'($urandom);
      if ($urandom_range(399) == 0) w.func = 3'($urandom_range(7, 1));
      else w.func = lcdn_pkg::FUNC_TICK;
      send_lcd_word(w, 1'b0, '0);
    end
  endtask

  task automatic random_lcd_word();
    lcdn_pkg::in_word_t w;
    int unsigned pick;
    int t;
    pick = $urandom_range(99);
    w.value = 8'($urandom);
    if (pick < 80) begin
      w.func = lcdn_pkg::FUNC_TICK;
    end else if (pick < 83) begin
      w.func = lcdn_pkg::FUNC_CMD;
    end else if (pick < 87) begin
      w.func = lcdn_pkg::FUNC_CHAR;
    end else if (pick < 89) begin
      w.func = lcdn_pkg::FUNC_CLEAR;
    end else if (pick < 91) begin
      w.func = lcdn_pkg::FUNC_HOME;
    end else if (pick < 99) begin
      w.func = lcdn_pkg::FUNC_CURSOR;
      if ($urandom_range(3) != 0) begin
        t = int'(cur_pos) + int'($urandom_range(4)) - 2;
        if (t < 0) t = 0;
      end else begin
        t = int'($urandom_range(255, 80));
      end
      w.value = 8'(t);
    end else begin
      w.func = FUNC_UNUSED;
    end
    send_lcd_word(w, 1'b0, '0);
  endtask

  task automatic set_waits(input logic [9:0] cmd_us, input logic [11:0] clr_us);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lcd_words_due.size() != 0) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= lcdn_pkg::CFG_COMMAND_WAIT;
    cfg_data_i <= 12'(cmd_us);
    @(negedge clk_i);
    cfg_idx_i <= lcdn_pkg::CFG_CLEAR_WAIT;
    cfg_data_i <= clr_us;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cmd_wait = cmd_us;
    clr_wait = clr_us;
  endtask

  initial begin : receiver
    int hold_left = 0;
    bit hold_ack = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_tog != hold_ack) begin
        hold_ack = hold_tog;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 31);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lcd_words_due.size() == 0) begin
        if (bad_words < 10) $display("unexpected result word: %s", show_word(out_word_o));
        bad_words++;
      end else begin
        due_word = lcd_words_due.pop_front();
        if (out_word_o !== due_word) begin
          if (bad_words < 10) begin
            $display("mismatch: expected %s", show_word(due_word));
            $display("          got      %s", show_word(out_word_o));
          end
          bad_words++;
        end
      end
    end
  end

  initial begin
    #1ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    lcdn_pkg::in_word_t w;
    directed = '{
      '{lcdn_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1, AT_RESET},
      '{FUNC_UNUSED, 8'hFF, 1'b0, 1'b1, AT_RESET},
      '{lcdn_pkg::FUNC_CURSOR, 8'd80, 1'b0, 1'b1, RANGE_REFUSED},
      '{lcdn_pkg::FUNC_CURSOR, 8'hFF, 1'b0, 1'b1, RANGE_REFUSED},
      '{lcdn_pkg::FUNC_CURSOR, 8'h00, 1'b0, 1'b1, AT_RESET},
      '{lcdn_pkg::FUNC_CMD, 8'hFF, 1'b0, 1'b1, CMD_TAKEN},
      '{lcdn_pkg::FUNC_HOME, 8'h5A, 1'b0, 1'b1, BUSY_REFUSED},
      '{lcdn_pkg::FUNC_TICK, 8'hFF, 1'b0, 1'b1, HIGH_SET},
      '{lcdn_pkg::FUNC_TICK, 8'h00, 1'b1, 1'b1, HIGH_STROBE},
      '{lcdn_pkg::FUNC_CHAR, 8'h3C, 1'b1, 1'b0, AT_RESET}
    };
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      w.func = directed[i].func;
      w.value = directed[i].value;
      send_lcd_word(w, directed[i].typed, directed[i].want);
      if (directed[i].run_out) tick_through_sequence();
    end

    // no idling here; hold the output long enough to back up the input
    set_waits(10'd0, 12'd0);
    idle_on = 1'b0;
    hold_tog = ~hold_tog;
    repeat (75) random_lcd_word();
    idle_on = 1'b1;
    repeat (75) random_lcd_word();
    tick_through_sequence();

    // start power-up init and watch the first ticks of its long wait
    w.func = lcdn_pkg::FUNC_INIT;
    w.value = 8'($urandom);
    send_lcd_word(w, 1'b0, '0);
    repeat (20) begin
      w.func = lcdn_pkg::FUNC_TICK;
      w.value = 8'($urandom);
      send_lcd_word(w, 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int n = 0; n < 20000 && lcd_words_due.size() != 0; n++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (bad_words == 0 && lcd_words_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
